[rtl/core/dxt_block_decoder_macros.svh]
// Assertion macros shared by the checker of the block decoder.
`ifndef DXT_BLOCK_DECODER_MACROS_SVH
`define DXT_BLOCK_DECODER_MACROS_SVH

// Implication that holds in the same cycle.
`define DXT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dxt block decoder check failed");

// Implication that holds in the next cycle.
`define DXT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dxt block decoder check failed");

`endif

[rtl/core/dxt_pkg.sv]
// Types, constants and palette arithmetic of the block decoder.
package dxt_pkg;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [3:0] LAST_PIXEL = 4'd15;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    typedef struct packed {
        logic        kind;
        logic [63:0] color_block;
        logic [63:0] alpha_block;
    } t_in_word;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [3:0] pixel_index;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_rgba;

    // One classified block with its palettes resolved.
    typedef struct packed {
        logic            dxt5;
        logic [31:0]     cidx;
        logic [47:0]     aidx;
        t_rgba [3:0]     cpal;
        logic [7:0][7:0] apal;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    // Reciprocal multiplications, exact over the ranges the palettes produce.
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'd683;
        return p[18:11];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [21:0] p;
        p = 22'(x) * 22'd1639;
        return p[20:13];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'd2341;
        return p[21:14];
    endfunction

endpackage

[rtl/core/dxt_front.sv]
// Front end: accepts a block, builds its color and alpha palettes, holds one entry.
module dxt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  dxt_pkg::t_in_word i_block,
    input  logic              i_q_full,
    output logic              o_push,
    output dxt_pkg::t_entry   o_entry,
    output logic              o_busy
);
    import dxt_pkg::*;

    logic   r_valid, n_valid;
    t_entry r_entry, n_entry;

    logic [15:0] e0, e1;
    logic [7:0]  a0, a1;
    logic        four;
    logic [7:0]  c0 [3];
    logic [7:0]  c1 [3];
    logic [7:0]  p2 [3];
    logic [7:0]  p3 [3];
    logic [8:0]  half;
    logic [10:0] s7, s5;

    assign e0   = i_block.color_block[15:0];
    assign e1   = i_block.color_block[31:16];
    assign a0   = i_block.alpha_block[7:0];
    assign a1   = i_block.alpha_block[15:8];
    assign four = i_block.kind || (e0 > e1);

    assign c0[0] = widen5(e0[15:11]);
    assign c0[1] = widen6(e0[10:5]);
    assign c0[2] = widen5(e0[4:0]);
    assign c1[0] = widen5(e1[15:11]);
    assign c1[1] = widen6(e1[10:5]);
    assign c1[2] = widen5(e1[4:0]);

    always_comb begin
        half = '0;
        for (int ch = 0; ch < 3; ch++) begin
            half = 9'(c0[ch]) + 9'(c1[ch]) + 9'd1;
            if (four) begin
                p2[ch] = div3({1'b0, c0[ch], 1'b0} + 10'(c1[ch]) + 10'd1);
                p3[ch] = div3(10'(c0[ch]) + {1'b0, c1[ch], 1'b0} + 10'd1);
            end else begin
                p2[ch] = half[8:1];
                p3[ch] = 8'd0;
            end
        end
    end

    always_comb begin
        n_entry.dxt5 = i_block.kind;
        n_entry.cidx = i_block.color_block[63:32];
        n_entry.aidx = i_block.alpha_block[63:16];
        n_entry.cpal[0] = '{r: c0[0], g: c0[1], b: c0[2], a: ALPHA_OPAQUE};
        n_entry.cpal[1] = '{r: c1[0], g: c1[1], b: c1[2], a: ALPHA_OPAQUE};
        n_entry.cpal[2] = '{r: p2[0], g: p2[1], b: p2[2], a: ALPHA_OPAQUE};
        n_entry.cpal[3] = '{r: p3[0], g: p3[1], b: p3[2],
                            a: four ? ALPHA_OPAQUE : ALPHA_CLEAR};
        n_entry.apal[0] = a0;
        n_entry.apal[1] = a1;
        s7 = '0;
        s5 = '0;
        for (int k = 2; k < 8; k++) begin
            if (a0 > a1) begin
                s7 = 11'(a0) * 11'(8 - k) + 11'(a1) * 11'(k - 1) + 11'd3;
                n_entry.apal[k] = div7(s7);
            end else if (k == 6) begin
                n_entry.apal[k] = 8'd0;
            end else if (k == 7) begin
                n_entry.apal[k] = 8'd255;
            end else begin
                s5 = 11'(a0) * 11'(6 - k) + 11'(a1) * 11'(k - 1) + 11'd2;
                n_entry.apal[k] = div5(s5);
            end
        end
    end

    assign o_push  = r_valid && !i_q_full;
    assign o_busy  = r_valid && i_q_full;
    assign o_entry = r_entry;

    always_comb begin
        n_valid = r_valid;
        if (i_take) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_entry <= n_entry;
        end
    end

endmodule

[rtl/core/dxt_queue.sv]
// Short queue of classified blocks between the front end and the pixel stage.
module dxt_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  dxt_pkg::t_entry    i_entry,
    input  logic               i_pop,
    output dxt_pkg::t_entry    o_head,
    output dxt_pkg::t_q_status o_status
);
    import dxt_pkg::*;

    t_entry               r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wptr, n_wptr;
    logic [Q_PTR_W-1:0]   r_rptr, n_rptr;
    logic [Q_CNT_W-1:0]   r_count, n_count;

    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_slot[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_entry;
        end
    end

endmodule

[rtl/core/dxt_back.sv]
// Pixel stage: walks the head block's indices and emits one pixel word per cycle while the queue holds a block.
module dxt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dxt_pkg::t_entry    i_head,
    input  dxt_pkg::t_q_status i_status,
    output logic               o_pop,
    output dxt_pkg::t_out_word o_result,
    output logic               o_strobe
);
    import dxt_pkg::*;

    logic [3:0] r_cnt, n_cnt;
    logic       r_strobe;
    t_out_word  r_result, n_result;
    logic       run;
    logic [1:0] code;
    logic [2:0] acode;
    logic [5:0] abase;
    t_rgba      color;

    assign run   = !i_status.empty;
    assign o_pop = run && (r_cnt == LAST_PIXEL);
    assign abase = 6'(r_cnt) * 6'd3;
    assign code  = i_head.cidx[{r_cnt, 1'b0} +: 2];
    assign acode = i_head.aidx[abase +: 3];
    assign color = i_head.cpal[code];

    always_comb begin
        n_result.red         = color.r;
        n_result.green       = color.g;
        n_result.blue        = color.b;
        n_result.alpha       = i_head.dxt5 ? i_head.apal[acode] : color.a;
        n_result.pixel_index = r_cnt;
        n_result.last        = (r_cnt == LAST_PIXEL);
        n_cnt                = run ? r_cnt + 1'b1 : r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_strobe <= run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (run) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;
    assign o_strobe = r_strobe;

endmodule

[rtl/core/dxt_block_decoder.sv]
// An accepted block passes the front register, a queue slot and the pixel result register
// before its first pixel shows. Output is one pixel word per cycle while the queue holds a block.
// The pixel stage walking 16 indices limits the block rate; the two-entry queue and the
// front register hold up to three blocks, the one being walked included, then busy rises.
// Synchronous active-low reset empties the front register and queue and drops strobe.
module dxt_block_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  dxt_pkg::t_in_word  i_block,
    output logic               busy,
    output logic               strobe,
    output dxt_pkg::t_out_word o_result
);
    import dxt_pkg::*;

    logic      take, push, pop;
    t_entry    front_entry, head;
    t_q_status q_status;

    assign take = start && !busy;

    dxt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_block  (i_block),
        .i_q_full (q_status.full),
        .o_push   (push),
        .o_entry  (front_entry),
        .o_busy   (busy)
    );

    dxt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (front_entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    dxt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_status (q_status),
        .o_pop    (pop),
        .o_result (o_result),
        .o_strobe (strobe)
    );

endmodule

[rtl/core/dxt_block_decoder_checker.sv]
// Port-level checker of the block decoder and its bind to the top level.
`include "dxt_block_decoder_macros.svh"

module dxt_block_decoder_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               busy,
    input logic               strobe,
    input dxt_pkg::t_out_word o_result
);
    import dxt_pkg::*;

    // A block streams out its sixteen words without gaps.
    `DXT_ASSERT_NEXT(a_no_gap, strobe && !o_result.last, strobe)
    `DXT_ASSERT_NEXT(a_index_steps, strobe && !o_result.last,
                     o_result.pixel_index == $past(o_result.pixel_index) + 4'd1)
    `DXT_ASSERT_SAME(a_last_flag, strobe, o_result.last == (o_result.pixel_index == LAST_PIXEL))
    // After an idle cycle, output restarts at the first pixel of a block.
    `DXT_ASSERT_SAME(a_starts_at_zero, $rose(strobe), o_result.pixel_index == 4'd0)
    // Input only backs up while the pixel stage is already streaming.
    `DXT_ASSERT_SAME(a_busy_streaming, busy, strobe)

endmodule

bind dxt_block_decoder dxt_block_decoder_checker u_checker (.*);
